FILE: sv/h264_access_unit_order_checker_core_assert.svh
// Assertion macros shared by the access unit order checker modules.
// All assume a clock named clk and an active-low reset named rst_n.
`ifndef H264_ACCESS_UNIT_ORDER_CHECKER_CORE_ASSERT_SVH
`define H264_ACCESS_UNIT_ORDER_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define AUOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AUOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/auoc_pkg.sv
package auoc_pkg;

  // Frame class codes carried through the queue
  localparam logic [2:0] KIND_SPS   = 3'd0;
  localparam logic [2:0] KIND_PPS   = 3'd1;
  localparam logic [2:0] KIND_IDR   = 3'd2;
  localparam logic [2:0] KIND_P     = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  // Tracker state codes
  localparam logic [2:0] TRK_NONE = 3'd0;
  localparam logic [2:0] TRK_SPS  = 3'd1;
  localparam logic [2:0] TRK_PPS  = 3'd2;
  localparam logic [2:0] TRK_IDR  = 3'd3;
  localparam logic [2:0] TRK_P    = 3'd4;

  // Verdict codes
  localparam logic [1:0] VERD_INCOMPLETE = 2'd0;
  localparam logic [1:0] VERD_USABLE     = 2'd1;
  localparam logic [1:0] VERD_FATAL      = 2'd2;
  localparam logic [1:0] VERD_NEW_BEGIN  = 2'd3;

  // Queue between front and back (depth at least 2)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int KIND_W  = 3;
  localparam int COUNT_W = 8;

  typedef logic [KIND_W-1:0] kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a raw frame kind onto a class code; unused codes count as other
  function automatic kind_t classify(input logic [2:0] raw);
    kind_t k;
    begin
      unique case (raw)
        3'd0:    k = KIND_SPS;
        3'd1:    k = KIND_PPS;
        3'd2:    k = KIND_IDR;
        3'd3:    k = KIND_P;
        default: k = KIND_OTHER;
      endcase
      return k;
    end
  endfunction

endpackage

FILE: sv/auoc_front.sv
module auoc_front
  import auoc_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_frame_kind,
  input  q_stat_t    q_stat,
  output logic       push,
  output kind_t      push_kind
);

  // Hold the sender while the queue is full
  assign in_stall = q_stat.full;

  // Classify and push each accepted transfer
  assign push      = in_valid && !q_stat.full;
  assign push_kind = classify(in_frame_kind);

endmodule

FILE: sv/auoc_queue.sv
`include "h264_access_unit_order_checker_core_assert.svh"

module auoc_queue
  import auoc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  kind_t   push_kind,
  input  logic    pop,
  output kind_t   pop_kind,
  output q_stat_t q_stat
);

  kind_t              entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_kind     = entry_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_kind;
    end
  end

  `AUOC_ASSERT_NEXT(a_q_push_only_grows, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count did not grow on push")
  `AUOC_ASSERT_NEXT(a_q_push_keeps_kind, push && q_stat.empty, pop_kind == $past(push_kind), "pushed kind not at queue head")
  `AUOC_ASSERT_NOW(a_q_no_overflow, push, !q_stat.full, "push into a full queue")
  `AUOC_ASSERT_NOW(a_q_no_underflow, pop, !q_stat.empty, "pop from an empty queue")

endmodule

FILE: sv/auoc_back.sv
`include "h264_access_unit_order_checker_core_assert.svh"

module auoc_back
  import auoc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_slices_per_picture,
  input  q_stat_t    q_stat,
  input  kind_t      pop_kind,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict
);

  logic [COUNT_W-1:0] spp_r;
  logic [2:0]         trk_r, trk_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r;
  logic [1:0]         verdict_r, verdict_nxt;

  logic [COUNT_W-1:0] cnt_step;
  logic               step_done;
  logic [COUNT_W-1:0] cnt_after;
  logic               is_sps, is_pps, is_idr, is_p;

  assign is_sps = (pop_kind == KIND_SPS);
  assign is_pps = (pop_kind == KIND_PPS);
  assign is_idr = (pop_kind == KIND_IDR);
  assign is_p   = (pop_kind == KIND_P);

  // Take the queue head when the output register is free or being drained
  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  // Count a slice where the state calls for it, then check completion
  always_comb begin
    if ((trk_r == TRK_PPS) || (trk_r == TRK_IDR && is_idr) || (trk_r == TRK_P && is_p)) begin
      cnt_step = cnt_r + 1'b1;
    end else begin
      cnt_step = cnt_r;
    end
    step_done = (cnt_step >= spp_r);
    cnt_after = step_done ? '0 : cnt_step;
  end

  // Tracker transition and verdict
  always_comb begin
    trk_nxt     = trk_r;
    cnt_nxt     = cnt_r;
    verdict_nxt = VERD_INCOMPLETE;
    unique case (trk_r)
      TRK_SPS: begin
        if (is_pps) begin
          trk_nxt = TRK_PPS;
        end else begin
          verdict_nxt = VERD_FATAL;
        end
      end
      TRK_PPS: begin
        if (is_idr) begin
          trk_nxt     = TRK_IDR;
          cnt_nxt     = cnt_after;
          verdict_nxt = step_done ? VERD_USABLE : VERD_INCOMPLETE;
        end else begin
          verdict_nxt = VERD_FATAL;
        end
      end
      TRK_IDR: begin
        cnt_nxt     = cnt_after;
        verdict_nxt = step_done ? VERD_USABLE : VERD_INCOMPLETE;
        if (is_p) begin
          if (cnt_after != '0) begin
            verdict_nxt = VERD_FATAL;
          end else if (spp_r <= COUNT_W'(1)) begin
            trk_nxt     = TRK_P;
            cnt_nxt     = '0;
            verdict_nxt = VERD_USABLE;
          end else begin
            trk_nxt     = TRK_P;
            cnt_nxt     = COUNT_W'(1);
            verdict_nxt = VERD_INCOMPLETE;
          end
        end else if (!is_idr) begin
          verdict_nxt = VERD_FATAL;
        end
      end
      TRK_P: begin
        cnt_nxt     = cnt_after;
        verdict_nxt = step_done ? VERD_USABLE : VERD_INCOMPLETE;
        if (!is_p) begin
          verdict_nxt = VERD_FATAL;
        end
      end
      default: begin
        if (is_sps) begin
          cnt_nxt = '0;
          trk_nxt = TRK_SPS;
        end else begin
          verdict_nxt = VERD_FATAL;
        end
      end
    endcase
    // Drop back to none on an order error
    if (verdict_nxt == VERD_FATAL) begin
      trk_nxt = TRK_NONE;
    end
    // An SPS always restarts the sequence
    if (is_sps) begin
      trk_nxt     = TRK_SPS;
      verdict_nxt = VERD_NEW_BEGIN;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r       <= COUNT_W'(1);
      trk_r       <= TRK_NONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        spp_r <= cfg_slices_per_picture;
      end
      if (pop) begin
        trk_r       <= trk_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  `AUOC_ASSERT_NEXT(a_fatal_to_none, pop && verdict_nxt == VERD_FATAL, trk_r == TRK_NONE, "fatal verdict left tracker active")
  `AUOC_ASSERT_NEXT(a_usable_clears, pop && verdict_nxt == VERD_USABLE, cnt_r == '0, "usable verdict left counter set")
  `AUOC_ASSERT_NEXT(a_sps_new_begin, pop && is_sps, out_verdict == VERD_NEW_BEGIN && trk_r == TRK_SPS, "SPS did not restart sequence")
  `AUOC_ASSERT_NOW(a_pop_has_room, pop, !q_stat.empty && (!out_valid_r || !out_stall), "pop without data or room")

endmodule

FILE: sv/h264_access_unit_order_checker_core.sv
// Path: an input transfer is written into the queue, and its verdict is then registered in the output register.
// Throughput: one frame per cycle while out_stall is low; the tracker in the back stage updates on each pop.
// A two-entry queue parts input from tracker; the output register parts tracker from output.
// Reset (rst_n low, synchronous): tracker to none, counter to zero, queue and output emptied,
// slice count register to 1.
module h264_access_unit_order_checker_core
  import auoc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_slices_per_picture,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_frame_kind,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict
);

  q_stat_t q_stat;
  logic    push;
  kind_t   push_kind;
  logic    pop;
  kind_t   pop_kind;

  // Accept register writes at any time
  assign cfg_ready = 1'b1;

  auoc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_kind (in_frame_kind),
    .q_stat        (q_stat),
    .push          (push),
    .push_kind     (push_kind)
  );

  auoc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_kind (push_kind),
    .pop       (pop),
    .pop_kind  (pop_kind),
    .q_stat    (q_stat)
  );

  auoc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid && cfg_ready),
    .cfg_slices_per_picture (cfg_slices_per_picture),
    .q_stat                 (q_stat),
    .pop_kind               (pop_kind),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_verdict            (out_verdict)
  );

endmodule
